// ===== src/ctf_pkg.sv =====
// Package for the complementary tilt filter: widths, register indexes,
// arctangent table and the sequencer state type. No dependencies.
package ctf_pkg;

	localparam int CordicSteps = 16;
	localparam int StepW = $clog2(CordicSteps + 1);
	localparam logic signed [31:0] PiQ16 = 32'sd205887;

	localparam logic [2:0] RegRateGain = 3'd0;
	localparam logic [2:0] RegGyroWeight = 3'd1;
	localparam logic [2:0] RegAccelWeight = 3'd2;
	localparam logic [2:0] RegMagLow = 3'd3;
	localparam logic [2:0] RegMagHigh = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INTEG,
		ST_CORDIC,
		ST_BLEND,
		ST_DONE
	} state_t;

	// Arctangent of 2^-i in Q16.16 radians.
	function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0: r = 32'sd51472;
			5'd1: r = 32'sd30386;
			5'd2: r = 32'sd16055;
			5'd3: r = 32'sd8150;
			5'd4: r = 32'sd4091;
			5'd5: r = 32'sd2047;
			5'd6: r = 32'sd1024;
			5'd7: r = 32'sd512;
			5'd8: r = 32'sd256;
			5'd9: r = 32'sd128;
			5'd10: r = 32'sd64;
			5'd11: r = 32'sd32;
			5'd12: r = 32'sd16;
			5'd13: r = 32'sd8;
			5'd14: r = 32'sd4;
			5'd15: r = 32'sd2;
			5'd16: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== src/ctf_serial_mac.sv =====
// Bit-serial multiply-accumulate: acc + a*b, one multiplier bit a cycle.
// Uses nothing from ctf_pkg or any other file.
module ctf_serial_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] mcand,
	input  logic [15:0]        mplier,
	input  logic signed [49:0] addend,
	output logic               done,
	output logic signed [49:0] acc
);

	logic [15:0] mplier_q;
	logic signed [49:0] shifted_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;

	// One multiplier bit per cycle: add the shifted multiplicand when the bit is set.
	// The done flag rises the cycle after the last bit, once the sum is final.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			done_q <= (cnt_q == 5'd15);
			if (cnt_q == 5'd15) begin
				busy_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc <= addend;
			mplier_q <= mplier;
			shifted_q <= 50'(mcand);
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc <= acc + shifted_q;
			end
			mplier_q <= {1'b0, mplier_q[15:1]};
			shifted_q <= shifted_q <<< 1;
		end
	end

	assign done = done_q;

endmodule

// ===== src/ctf_cordic.sv =====
// Iterative vectoring CORDIC for atan2 of two axes, one rotation a cycle.
// Depends on ctf_pkg for the step count, pi and the arctangent table.
module ctf_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] num,
	input  logic signed [15:0] den,
	output logic               done,
	output logic signed [31:0] angle
);

	logic signed [27:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [ctf_pkg::StepW-1:0] step_q;
	logic busy_q;
	logic [4:0] sh;
	logic signed [27:0] xs, ys, x0, y0;

	assign sh = 5'(step_q);
	assign xs = x_q >>> sh;
	assign ys = y_q >>> sh;
	assign x0 = 28'(den) <<< 8;
	assign y0 = 28'(num) <<< 8;

	// Sequence the rotations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= (num != 16'sd0) || (den != 16'sd0);
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == ctf_pkg::StepW'(ctf_pkg::CordicSteps - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Rotation datapath with the left-half-plane pre-turn by pi.
	always_ff @(posedge clk) begin
		if (start) begin
			if (den < 16'sd0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= (num >= 16'sd0) ? ctf_pkg::PiQ16 : -ctf_pkg::PiQ16;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 28'sd0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ctf_pkg::atan_lut(sh);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ctf_pkg::atan_lut(sh);
			end
		end
	end

	assign done = !busy_q;
	assign angle = z_q;

endmodule

// ===== src/complementary_tilt_filter.sv =====
// Top level of the complementary tilt filter: sequencer, config registers,
// magnitude check and sharing of ctf_serial_mac and ctf_cordic. Uses ctf_pkg.
//
//  channel   signals                                     direction
//  in        in_valid/in_ready, accel_*, gyro_*           to block
//  out       out_valid/out_ready, angle_*, accel_trusted  from block
//  cfg       cfg_we, cfg_index, cfg_data                  to block
//
// Without a blend a word takes three serial multiplies by the rate gain.
// With a blend the two CORDIC runs (16 steps each) and four more serial
// multiplies follow; the single bit-serial multiplier serves every multiply.
// Reset clears the angles and loads the register defaults. A result is
// loaded into the output register and waits there; the next word is taken
// once the result is loaded there, even before it has been handed over.
module complementary_tilt_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] angle_x,
	output logic signed [31:0] angle_y,
	output logic signed [31:0] angle_z,
	output logic               accel_trusted,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	ctf_pkg::state_t state_q, state_d;
	logic [15:0] rate_gain_q, gyro_weight_q, accel_weight_q;
	logic [16:0] mag_low_q, mag_high_q;
	logic signed [31:0] ang_q [3];
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [15:0] g_q [3];
	logic signed [31:0] acc_ang_q;
	logic trusted_q;
	logic [1:0] axis_q;
	logic phase_q;
	logic [1:0] sub_q;
	logic mac_start, mac_done, cor_start, cor_done;
	logic signed [31:0] mac_mcand, cor_angle;
	logic [15:0] mac_mplier;
	logic signed [49:0] mac_addend, mac_acc;
	logic [17:0] mag;
	logic trusted_now, accept;

	assign accept = in_valid && in_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_gain_q <= 16'd66;
			gyro_weight_q <= 16'd32112;
			accel_weight_q <= 16'd656;
			mag_low_q <= 17'd12000;
			mag_high_q <= 17'd20000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctf_pkg::RegRateGain: rate_gain_q <= cfg_data[15:0];
				ctf_pkg::RegGyroWeight: gyro_weight_q <= cfg_data[15:0];
				ctf_pkg::RegAccelWeight: accel_weight_q <= cfg_data[15:0];
				ctf_pkg::RegMagLow: mag_low_q <= cfg_data;
				ctf_pkg::RegMagHigh: mag_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// L1 magnitude of the captured acceleration.
	function automatic logic [16:0] abs16(input logic signed [15:0] v);
		return v[15] ? 17'(-18'(v)) : 17'(v);
	endfunction
	assign mag = 18'(abs16(ax_q)) + 18'(abs16(ay_q)) + 18'(abs16(az_q));
	assign trusted_now = (mag > 18'(mag_low_q)) && (mag < 18'(mag_high_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctf_pkg::ST_IDLE: if (accept) state_d = ctf_pkg::ST_INTEG;
			ctf_pkg::ST_INTEG: if (sub_q == 2'd1 && mac_done && axis_q == 2'd2)
				state_d = trusted_q ? ctf_pkg::ST_CORDIC : ctf_pkg::ST_DONE;
			ctf_pkg::ST_CORDIC: if (sub_q == 2'd1 && cor_done) state_d = ctf_pkg::ST_BLEND;
			ctf_pkg::ST_BLEND: if (sub_q == 2'd2 && mac_done && phase_q)
				state_d = (axis_q == 2'd1) ? ctf_pkg::ST_DONE : ctf_pkg::ST_CORDIC;
			ctf_pkg::ST_DONE: if (!out_valid || out_ready) state_d = ctf_pkg::ST_IDLE;
			default: state_d = ctf_pkg::ST_IDLE;
		endcase
	end

	// Unit starts and operand selection.
	always_comb begin
		mac_start = (state_q == ctf_pkg::ST_INTEG || state_q == ctf_pkg::ST_BLEND)
			&& sub_q == 2'd0;
		cor_start = state_q == ctf_pkg::ST_CORDIC && sub_q == 2'd0;
		if (state_q == ctf_pkg::ST_INTEG) begin
			mac_mcand = 32'(g_q[axis_q]);
			mac_mplier = rate_gain_q;
			mac_addend = 50'(ang_q[axis_q]);
		end else if (!phase_q) begin
			mac_mcand = ang_q[axis_q];
			mac_mplier = gyro_weight_q;
			mac_addend = 50'sd16384;
		end else begin
			mac_mcand = acc_ang_q;
			mac_mplier = accel_weight_q;
			mac_addend = mac_acc;
		end
	end

	// Sequencer counters and data capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctf_pkg::ST_IDLE;
			sub_q <= '0;
			axis_q <= '0;
			phase_q <= 1'b0;
			out_valid <= 1'b0;
			trusted_q <= 1'b0;
			acc_ang_q <= '0;
			angle_x <= '0;
			angle_y <= '0;
			angle_z <= '0;
			accel_trusted <= 1'b0;
			for (int i = 0; i < 3; i++) ang_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ctf_pkg::ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ctf_pkg::ST_IDLE: begin
					sub_q <= '0;
					axis_q <= '0;
					phase_q <= 1'b0;
				end
				ctf_pkg::ST_INTEG: begin
					trusted_q <= trusted_now;
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else if (mac_done) begin
						ang_q[axis_q] <= ctf_pkg::sat32(mac_acc);
						sub_q <= '0;
						axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
					end
				end
				ctf_pkg::ST_CORDIC: begin
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else if (cor_done) begin
						acc_ang_q <= cor_angle;
						sub_q <= '0;
						phase_q <= 1'b0;
					end
				end
				ctf_pkg::ST_BLEND: begin
					if (sub_q == 2'd0) sub_q <= 2'd2;
					else if (mac_done) begin
						sub_q <= '0;
						if (!phase_q) phase_q <= 1'b1;
						else begin
							ang_q[axis_q] <= ctf_pkg::sat32(mac_acc >>> 15);
							axis_q <= axis_q + 2'd1;
						end
					end
				end
				ctf_pkg::ST_DONE: begin
					if (!out_valid || out_ready) begin
						angle_x <= ang_q[0];
						angle_y <= ang_q[1];
						angle_z <= ang_q[2];
						accel_trusted <= trusted_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			g_q[0] <= gyro_x;
			g_q[1] <= gyro_y;
			g_q[2] <= gyro_z;
		end
	end

	assign in_ready = state_q == ctf_pkg::ST_IDLE;

	ctf_serial_mac u_mac (
		.clk(clk), .arst_n(arst_n), .start(mac_start), .mcand(mac_mcand),
		.mplier(mac_mplier), .addend(mac_addend), .done(mac_done), .acc(mac_acc)
	);

	ctf_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .num(az_q),
		.den(axis_q == 2'd0 ? ax_q : ay_q), .done(cor_done), .angle(cor_angle)
	);

	// Blend only follows a trusted magnitude.
	a_blend_trusted: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ctf_pkg::ST_CORDIC |-> trusted_q) else $error("blend untrusted");
	// Input is refused while a word is in work.
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ctf_pkg::ST_IDLE |-> !in_ready) else $error("accept while busy");
	// A new result only appears out of the done state.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ctf_pkg::ST_DONE) else $error("stray result");

endmodule
